### hw/rtl/psk_pkg.sv
// Shared types, constants and the symbol transition table of the PSK modulator.
`default_nettype none

package psk_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_LEN  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEP   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE   = 8'd3;

    typedef struct packed {
        logic [31:0] phase_step;
        logic [9:0]  samples_per_symbol;
        logic [15:0] ramp_step;
        logic [14:0] amplitude;
    } cfg_t;

    localparam logic [31:0] RST_PHASE_STEP = 32'd536870912;
    localparam logic [9:0]  RST_SYMBOL_LEN = 10'd256;
    localparam logic [15:0] RST_RAMP_STEP  = 16'd256;
    localparam logic [14:0] RST_AMPLITUDE  = 15'd22000;

    // envelope shapes
    typedef enum logic [2:0] {
        SH_ZERO,
        SH_POS,
        SH_NEG,
        SH_POS_NEG,
        SH_NEG_POS,
        SH_POS_ZERO,
        SH_NEG_ZERO,
        SH_ZERO_POS
    } shape_t;

    typedef struct packed {
        shape_t     i_shape;
        shape_t     q_shape;
        logic [2:0] next_phase;
    } trans_t;

    localparam logic [2:0] PHASE_OFF = 3'd4;
    localparam logic [2:0] SYM_LAST  = 3'd5;
    localparam logic [2:0] SYM_SAME  = 3'd0;

    // [symbol][present phase]
    localparam trans_t TRANS_TAB [6][5] = '{
        '{ '{SH_POS, SH_POS, 3'd0}, '{SH_NEG, SH_POS, 3'd1}, '{SH_NEG, SH_NEG, 3'd2},
           '{SH_POS, SH_NEG, 3'd3}, '{SH_ZERO, SH_ZERO, 3'd4} },
        '{ '{SH_POS_NEG, SH_POS, 3'd1}, '{SH_NEG, SH_POS_NEG, 3'd2},
           '{SH_NEG_POS, SH_NEG, 3'd3}, '{SH_POS, SH_NEG_POS, 3'd0},
           '{SH_ZERO_POS, SH_ZERO_POS, 3'd0} },
        '{ '{SH_POS_NEG, SH_POS_NEG, 3'd2}, '{SH_NEG_POS, SH_POS_NEG, 3'd3},
           '{SH_NEG_POS, SH_NEG_POS, 3'd0}, '{SH_POS_NEG, SH_NEG_POS, 3'd1},
           '{SH_ZERO_POS, SH_ZERO_POS, 3'd0} },
        '{ '{SH_POS, SH_POS_NEG, 3'd3}, '{SH_NEG_POS, SH_POS, 3'd0},
           '{SH_NEG, SH_NEG_POS, 3'd1}, '{SH_POS_NEG, SH_NEG, 3'd2},
           '{SH_ZERO_POS, SH_ZERO_POS, 3'd0} },
        '{ '{SH_POS_ZERO, SH_POS_ZERO, 3'd4}, '{SH_NEG_ZERO, SH_POS_ZERO, 3'd4},
           '{SH_NEG_ZERO, SH_NEG_ZERO, 3'd4}, '{SH_POS_ZERO, SH_NEG_ZERO, 3'd4},
           '{SH_ZERO, SH_ZERO, 3'd4} },
        '{ '{SH_POS, SH_POS, 3'd0}, '{SH_NEG_POS, SH_POS, 3'd0},
           '{SH_NEG_POS, SH_NEG_POS, 3'd0}, '{SH_POS, SH_NEG_POS, 3'd0},
           '{SH_ZERO_POS, SH_ZERO_POS, 3'd0} }
    };

    // sine polynomial, Q14 coefficients
    localparam int POLY_A  = 51472;
    localparam int POLY_B  = 21024;
    localparam int POLY_C  = 2320;
    localparam int QUARTER = 16384;
    localparam int Q15_MAX = 32767;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // shared multiplier
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_SQ,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_Y,
        ST_MUL_I,
        ST_MUL_Q,
        ST_SCALE,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        SEL_ENV,
        SEL_SIN,
        SEL_COS
    } sine_sel_t;

endpackage

`default_nettype wire

### hw/rtl/psk_if.sv
// Handshake channel interfaces: symbol requests, audio results, configuration writes.
`default_nettype none

interface psk_sym_if
    import psk_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [2:0] next_symbol;

    modport source (output valid, output next_symbol, input ready);
    modport sink   (input valid, input next_symbol, output ready);
endinterface

interface psk_audio_if
    import psk_pkg::*;
;
    logic               valid;
    logic               ready;
    logic signed [15:0] audio_sample;
    logic               symbol_taken;

    modport source (output valid, output audio_sample, output symbol_taken, input ready);
    modport sink   (input valid, input audio_sample, input symbol_taken, output ready);
endinterface

interface psk_cfg_if
    import psk_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/psk_cfg_regs.sv
// Configuration register bank written through the configuration channel.
`default_nettype none

module psk_cfg_regs
    import psk_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    psk_cfg_if.sink    cfg,
    output cfg_t       cfg_q
);

    cfg_t cfg_reg;

    // writes are always accepted; ready is tied high
    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step         <= RST_PHASE_STEP;
            cfg_reg.samples_per_symbol <= RST_SYMBOL_LEN;
            cfg_reg.ramp_step          <= RST_RAMP_STEP;
            cfg_reg.amplitude          <= RST_AMPLITUDE;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PHASE_STEP: cfg_reg.phase_step         <= cfg.data;
                REG_SYMBOL_LEN: cfg_reg.samples_per_symbol <= cfg.data[9:0];
                REG_RAMP_STEP:  cfg_reg.ramp_step          <= cfg.data[15:0];
                REG_AMPLITUDE:  cfg_reg.amplitude          <= cfg.data[14:0];
                default:        ;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/psk_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none

module psk_mul
    import psk_pkg::*;
(
    input  wire                       clk,
    input  wire                       en,
    input  wire signed [MUL_A_W-1:0]  a,
    input  wire signed [MUL_B_W-1:0]  b,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/psk_core.sv
// Sequencer and datapath: phase, sine polynomial, envelope shaping and scaling.
`default_nettype none

module psk_core
    import psk_pkg::*;
#(
    parameter int MAX_SAMPLES_PER_SYMBOL = 512,
    parameter int SINE_TABLE_DEPTH       = 1024
)
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  cfg_t                       cfg_q,
    psk_sym_if.sink                    sym,
    psk_audio_if.source                audio,
    output logic                       mul_en,
    output logic signed [MUL_A_W-1:0]  mul_a,
    output logic signed [MUL_B_W-1:0]  mul_b,
    input  wire signed [MUL_P_W-1:0]   mul_prod
);

    localparam int POS_W  = $clog2(MAX_SAMPLES_PER_SYMBOL);
    localparam int CNT_W  = $clog2(MAX_SAMPLES_PER_SYMBOL + 1);
    localparam int CMP_W  = (CNT_W > 10) ? CNT_W : 10;
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int FRAC_W = 16 - IDX_W;
    localparam logic [15:0] X_MASK = 16'hFFFF << FRAC_W;
    localparam logic signed [MUL_P_W-1:0] ROUND_ADJ = MUL_P_W'((64'd1 << 30) - 64'd1);

    // control state
    state_t            state_reg, state_next;
    sine_sel_t         sel_reg, sel_next;
    logic [31:0]       phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [2:0]        ph_state_reg, ph_state_next;
    shape_t            i_shape_reg, i_shape_next;
    shape_t            q_shape_reg, q_shape_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [2:0]         sym_reg, sym_next;
    logic [31:0]        env_arg_reg, env_arg_next;
    logic [14:0]        z_reg, z_next;
    logic [1:0]         quad_reg, quad_next;
    logic [14:0]        z2_reg, z2_next;
    logic signed [15:0] s_reg, s_next;
    logic signed [15:0] c_reg, c_next;
    logic signed [15:0] env_reg, env_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [15:0] sample_reg, sample_next;
    logic               taken_reg, taken_next;

    // combinational helpers
    logic [CMP_W-1:0]   len_wide;
    logic [CNT_W-1:0]   len_eff;
    logic [POS_W:0]     pos_inc;
    logic               sym_end;
    logic               first_half;
    logic [31:0]        sine_arg;
    logic [15:0]        x_ang;
    logic [14:0]        z_calc;
    logic [14:0]        z2_now;
    logic [15:0]        t1;
    logic [15:0]        t2;
    logic [16:0]        y_raw;
    logic signed [15:0] y_mag;
    logic signed [15:0] y_val;
    logic signed [15:0] iv;
    logic signed [15:0] qv;
    logic signed [32:0] acc_sum;
    logic signed [MUL_P_W-1:0] adj;
    logic signed [MUL_P_W-1:0] quo;
    logic signed [15:0] sample_sat;
    logic               out_move;
    logic [2:0]         sym_idx;
    logic [2:0]         ph_idx;
    trans_t             trans;

    function automatic logic signed [15:0] shape_level(shape_t code,
                                                       logic signed [15:0] c,
                                                       logic first);
        logic signed [15:0] lvl;
        case (code)
            SH_POS:      lvl = 16'(Q15_MAX);
            SH_NEG:      lvl = -16'(Q15_MAX);
            SH_POS_NEG:  lvl = c;
            SH_NEG_POS:  lvl = -c;
            SH_POS_ZERO: lvl = first ? c : 16'sd0;
            SH_NEG_ZERO: lvl = first ? -c : 16'sd0;
            SH_ZERO_POS: lvl = first ? 16'sd0 : -c;
            default:     lvl = 16'sd0;
        endcase
        return lvl;
    endfunction

    // symbol length, capped, and end-of-symbol test
    always_comb
    begin
        len_wide = CMP_W'(cfg_q.samples_per_symbol);
        if (len_wide > CMP_W'(MAX_SAMPLES_PER_SYMBOL))
        begin
            len_eff = CNT_W'(MAX_SAMPLES_PER_SYMBOL);
        end
        else
        begin
            len_eff = len_wide[CNT_W-1:0];
        end
        pos_inc    = {1'b0, pos_reg} + (POS_W+1)'(1);
        sym_end    = pos_inc >= (POS_W+1)'(len_eff);
        first_half = {pos_reg, 1'b0} < (POS_W+1)'(len_eff);
    end

    // sine argument and quarter-wave reduction
    always_comb
    begin
        case (sel_reg)
            SEL_ENV: sine_arg = env_arg_reg;
            SEL_SIN: sine_arg = phase_reg;
            SEL_COS: sine_arg = phase_reg + QUARTER_TURN;
            default: sine_arg = phase_reg;
        endcase
        x_ang  = sine_arg[31:16] & X_MASK;
        z_calc = x_ang[14] ? (15'(QUARTER) - {1'b0, x_ang[13:0]}) : {1'b0, x_ang[13:0]};
        z2_now = mul_prod[28:14];
        t1     = 16'(POLY_B) - mul_prod[29:14];
        t2     = 16'(POLY_A) - mul_prod[29:14];
        y_raw  = mul_prod[30:14];
        y_mag  = (y_raw > 17'(Q15_MAX)) ? 16'(Q15_MAX) : signed'(y_raw[15:0]);
        y_val  = quad_reg[1] ? -y_mag : y_mag;
    end

    // envelope levels, accumulation and output scaling
    always_comb
    begin
        iv      = shape_level(i_shape_reg, env_reg, first_half);
        qv      = shape_level(q_shape_reg, env_reg, first_half);
        acc_sum = 33'(acc_reg) + 33'(signed'(mul_prod[31:0]));
        adj     = mul_prod[MUL_P_W-1] ? (mul_prod + ROUND_ADJ) : mul_prod;
        quo     = adj >>> 30;
        if (quo > MUL_P_W'(32767))
        begin
            sample_sat = 16'sh7FFF;
        end
        else if (quo < -MUL_P_W'(32768))
        begin
            sample_sat = 16'sh8000;
        end
        else
        begin
            sample_sat = quo[15:0];
        end
        sym_idx = (sym_reg > SYM_LAST) ? SYM_SAME : sym_reg;
        ph_idx  = (ph_state_reg > PHASE_OFF) ? PHASE_OFF : ph_state_reg;
        trans   = TRANS_TAB[sym_idx][ph_idx];
    end

    assign out_move     = (state_reg == ST_FINISH) && (!out_valid_reg || audio.ready);
    assign sym.ready    = (state_reg == ST_IDLE);
    assign audio.valid        = out_valid_reg;
    assign audio.audio_sample = sample_reg;
    assign audio.symbol_taken = taken_reg;

    // sequencer: next state, multiplier operands, register updates
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        ph_state_next  = ph_state_reg;
        i_shape_next   = i_shape_reg;
        q_shape_next   = q_shape_reg;
        out_valid_next = out_valid_reg && !audio.ready;
        sym_next       = sym_reg;
        env_arg_next   = env_arg_reg;
        z_next         = z_reg;
        quad_next      = quad_reg;
        z2_next        = z2_reg;
        s_next         = s_reg;
        c_next         = c_reg;
        env_next       = env_reg;
        acc_next       = acc_reg;
        sample_next    = sample_reg;
        taken_next     = taken_reg;
        mul_en         = 1'b1;
        mul_a          = '0;
        mul_b          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // envelope angle product starts right away
                mul_a = MUL_A_W'(pos_reg);
                mul_b = MUL_B_W'(cfg_q.ramp_step);
                if (sym.valid)
                begin
                    sym_next   = sym.next_symbol;
                    phase_next = phase_reg + cfg_q.phase_step;
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE:
            begin
                env_arg_next = {mul_prod[16:0], 15'd0} + QUARTER_TURN;
                sel_next     = SEL_ENV;
                state_next   = ST_SQ;
            end
            ST_SQ:
            begin
                z_next     = z_calc;
                quad_next  = x_ang[15:14];
                mul_a      = MUL_A_W'(z_calc);
                mul_b      = MUL_B_W'(z_calc);
                state_next = ST_T1;
            end
            ST_T1:
            begin
                z2_next    = z2_now;
                mul_a      = MUL_A_W'(POLY_C);
                mul_b      = MUL_B_W'(z2_now);
                state_next = ST_T2;
            end
            ST_T2:
            begin
                mul_a      = MUL_A_W'(z2_reg);
                mul_b      = MUL_B_W'(t1);
                state_next = ST_T3;
            end
            ST_T3:
            begin
                mul_a      = MUL_A_W'(z_reg);
                mul_b      = MUL_B_W'(t2);
                state_next = ST_Y;
            end
            ST_Y:
            begin
                mul_en = 1'b0;
                case (sel_reg)
                    SEL_ENV:
                    begin
                        env_next   = y_val;
                        sel_next   = SEL_SIN;
                        state_next = ST_SQ;
                    end
                    SEL_SIN:
                    begin
                        s_next     = y_val;
                        sel_next   = SEL_COS;
                        state_next = ST_SQ;
                    end
                    default:
                    begin
                        c_next     = y_val;
                        state_next = ST_MUL_I;
                    end
                endcase
            end
            ST_MUL_I:
            begin
                mul_a      = MUL_A_W'(iv);
                mul_b      = MUL_B_W'(s_reg);
                state_next = ST_MUL_Q;
            end
            ST_MUL_Q:
            begin
                acc_next   = mul_prod[31:0];
                mul_a      = MUL_A_W'(qv);
                mul_b      = MUL_B_W'(c_reg);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                mul_a      = MUL_A_W'(acc_sum);
                mul_b      = MUL_B_W'(cfg_q.amplitude);
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold the product until the output register frees up
                mul_en = 1'b0;
                if (out_move)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = sample_sat;
                    taken_next     = sym_end;
                    if (sym_end)
                    begin
                        pos_next      = '0;
                        i_shape_next  = trans.i_shape;
                        q_shape_next  = trans.q_shape;
                        ph_state_next = trans.next_phase;
                    end
                    else
                    begin
                        pos_next = pos_inc[POS_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= SEL_ENV;
            phase_reg     <= '0;
            pos_reg       <= '0;
            ph_state_reg  <= PHASE_OFF;
            i_shape_reg   <= SH_ZERO;
            q_shape_reg   <= SH_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            ph_state_reg  <= ph_state_next;
            i_shape_reg   <= i_shape_next;
            q_shape_reg   <= q_shape_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sym_reg     <= sym_next;
        env_arg_reg <= env_arg_next;
        z_reg       <= z_next;
        quad_reg    <= quad_next;
        z2_reg      <= z2_next;
        s_reg       <= s_next;
        c_reg       <= c_next;
        env_reg     <= env_next;
        acc_reg     <= acc_next;
        sample_reg  <= sample_next;
        taken_reg   <= taken_next;
    end

`ifndef SYNTHESIS
    // products start only after all three sine values are in
    a_seq_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL_I |-> $past(state_reg) == ST_Y && $past(sel_reg) == SEL_COS)
        else $error("product phase entered before cosine finished");

    // polynomial output never reaches the negative full-scale code
    a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL_I |-> s_reg != 16'sh8000 && c_reg != 16'sh8000
                               && env_reg != 16'sh8000)
        else $error("sine value out of Q15 range");

    // phase state stays within the table
    a_phase_state: assert property (@(posedge clk) disable iff (!rst_n)
        ph_state_reg <= PHASE_OFF)
        else $error("phase state out of range");

    // a result appears only out of the finishing step
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("output valid raised outside finish step");
`endif

endmodule

`default_nettype wire

### hw/rtl/psk_iq_shaped_modulator.sv
// PSK modulator top level: one shaped audio sample per symbol-channel request.
// Usage:
//   sym   - one request per audio sample tick, carrying next_symbol
//           (0 same, 1 +90, 2 +180, 3 -90, 4 off, 5 on; 6 and 7 act as 0).
//           next_symbol is used only when the tick ends a symbol.
//   audio - one result per request: saturated signed sample and symbol_taken.
//   cfg   - register writes (0 phase step, 1 symbol length, 2 ramp step,
//           3 amplitude); ready is always high, other indices are ignored.
//           Write only while no sample is in flight.
// Timing: one shared 34x17 multiplier under a sequencer does 16 products per
//   sample (three 4-step sine polynomials plus angle, I, Q and scaling). The
//   result is registered out of the finish step, and sym.ready returns in the
//   same cycle; a new request is taken only once the previous sample is done.
// Reset: carrier phase and symbol position clear, phase state is off, both
//   envelopes are zero, registers take their default values.
// Stall: a result waits in the output register while audio.ready is low; the
//   next request is still taken and its result waits in the finish step.
`default_nettype none

module psk_iq_shaped_modulator
    import psk_pkg::*;
#(
    parameter int MAX_SAMPLES_PER_SYMBOL = 512,
    parameter int SINE_TABLE_DEPTH       = 1024
)
(
    input  wire          clk,
    input  wire          rst_n,
    psk_sym_if.sink      sym,
    psk_audio_if.source  audio,
    psk_cfg_if.sink      cfg
);

    cfg_t                      cfg_q;
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_prod;

    psk_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    psk_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    psk_core #(
        .MAX_SAMPLES_PER_SYMBOL (MAX_SAMPLES_PER_SYMBOL),
        .SINE_TABLE_DEPTH       (SINE_TABLE_DEPTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_q    (cfg_q),
        .sym      (sym),
        .audio    (audio),
        .mul_en   (mul_en),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_prod (mul_prod)
    );

endmodule

`default_nettype wire

### verif/psk_sample_checker.sv
// Checker for the PSK modulator: watches the channels, predicts each sample and compares.
module psk_sample_checker
    import psk_pkg::*;
#(
    parameter int MAX_SPS    = 512,
    parameter int SINE_DEPTH = 1024
)
(
    input  wire  clk,
    input  wire  rst_n,
    psk_sym_if   sym,
    psk_audio_if audio,
    psk_cfg_if   cfg,
    output int   fails,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // carrier phase states
    localparam logic [2:0] PH_0   = 3'd0;
    localparam logic [2:0] PH_90  = 3'd1;
    localparam logic [2:0] PH_180 = 3'd2;
    localparam logic [2:0] PH_270 = 3'd3;

    typedef struct packed {
        logic signed [15:0] audio_sample;
        logic               symbol_taken;
    } sample_t;

    typedef struct packed {
        shape_t     i_sh;
        shape_t     q_sh;
        logic [2:0] nxt;
    } rule_t;

    // new shapes and phase, [symbol][present phase]
    localparam rule_t RULES [6][5] = '{
        '{ '{SH_POS, SH_POS, PH_0}, '{SH_NEG, SH_POS, PH_90}, '{SH_NEG, SH_NEG, PH_180},
           '{SH_POS, SH_NEG, PH_270}, '{SH_ZERO, SH_ZERO, PHASE_OFF} },
        '{ '{SH_POS_NEG, SH_POS, PH_90}, '{SH_NEG, SH_POS_NEG, PH_180},
           '{SH_NEG_POS, SH_NEG, PH_270}, '{SH_POS, SH_NEG_POS, PH_0},
           '{SH_ZERO_POS, SH_ZERO_POS, PH_0} },
        '{ '{SH_POS_NEG, SH_POS_NEG, PH_180}, '{SH_NEG_POS, SH_POS_NEG, PH_270},
           '{SH_NEG_POS, SH_NEG_POS, PH_0}, '{SH_POS_NEG, SH_NEG_POS, PH_90},
           '{SH_ZERO_POS, SH_ZERO_POS, PH_0} },
        '{ '{SH_POS, SH_POS_NEG, PH_270}, '{SH_NEG_POS, SH_POS, PH_0},
           '{SH_NEG, SH_NEG_POS, PH_90}, '{SH_POS_NEG, SH_NEG, PH_180},
           '{SH_ZERO_POS, SH_ZERO_POS, PH_0} },
        '{ '{SH_POS_ZERO, SH_POS_ZERO, PHASE_OFF}, '{SH_NEG_ZERO, SH_POS_ZERO, PHASE_OFF},
           '{SH_NEG_ZERO, SH_NEG_ZERO, PHASE_OFF}, '{SH_POS_ZERO, SH_NEG_ZERO, PHASE_OFF},
           '{SH_ZERO, SH_ZERO, PHASE_OFF} },
        '{ '{SH_POS, SH_POS, PH_0}, '{SH_NEG_POS, SH_POS, PH_0},
           '{SH_NEG_POS, SH_NEG_POS, PH_0}, '{SH_POS, SH_NEG_POS, PH_0},
           '{SH_ZERO_POS, SH_ZERO_POS, PH_0} }
    };

    // register copies
    logic [31:0] phase_step;
    logic [9:0]  sym_len;
    logic [15:0] ramp_step;
    logic [14:0] amp_reg;

    // modulator state
    logic [31:0] carrier_phase;
    int unsigned ramp_pos;
    logic [2:0]  phase_state;
    shape_t      i_shape;
    shape_t      q_shape;

    sample_t     expected_samples [$];
    sample_t     got;
    sample_t     want;
    int          mismatch_count;
    int          result_count;

    // Q15 sine from the quarter-wave polynomial, indexed by table entry
    function automatic int q15_sine(input logic [31:0] ph);
        longint unsigned idx;
        longint unsigned x;
        int unsigned     quad;
        int unsigned     r;
        int unsigned     z;
        int unsigned     z2;
        int unsigned     t;
        int unsigned     y;
        idx  = ({32'b0, ph} * 64'(SINE_DEPTH)) >> 32;
        x    = ((idx * 64'd65536) / 64'(SINE_DEPTH)) & 64'hFFFF;
        quad = 32'(x >> 14);
        r    = 32'(x) & 32'h3FFF;
        z    = (quad & 32'd1) ? (QUARTER - r) : r;
        z2   = (z * z) >> 14;
        t    = (POLY_C * z2) >> 14;
        t    = POLY_B - t;
        t    = (z2 * t) >> 14;
        t    = POLY_A - t;
        y    = (z * t) >> 14;
        if (y > Q15_MAX)
            y = Q15_MAX;
        return (quad >= 2) ? -int'(y) : int'(y);
    endfunction

    // envelope level at a position in the symbol
    function automatic int envelope_level(input shape_t sh, input int unsigned pos,
                                          input int unsigned len);
        logic [31:0] ang;
        logic        first_half;
        int          c;
        ang        = pos * ramp_step;
        ang        = ang << 15;
        first_half = (2 * pos) < len;
        c          = q15_sine(ang + QUARTER_TURN);
        case (sh)
            SH_POS:      return Q15_MAX;
            SH_NEG:      return -Q15_MAX;
            SH_POS_NEG:  return c;
            SH_NEG_POS:  return -c;
            SH_POS_ZERO: return first_half ? c : 0;
            SH_NEG_ZERO: return first_half ? -c : 0;
            SH_ZERO_POS: return first_half ? 0 : -c;
            default:     return 0;
        endcase
    endfunction

    // one sample tick: output sample, then symbol bookkeeping
    function automatic sample_t predict_sample(input logic [2:0] code);
        int unsigned len;
        int          s;
        int          c;
        int          iv;
        int          qv;
        longint      acc;
        longint      amp;
        logic [2:0]  sym_idx;
        logic [2:0]  ph_idx;
        rule_t       rule;
        sample_t     res;
        len = (sym_len > MAX_SPS) ? MAX_SPS : sym_len;
        carrier_phase = carrier_phase + phase_step;
        s   = q15_sine(carrier_phase);
        c   = q15_sine(carrier_phase + QUARTER_TURN);
        iv  = envelope_level(i_shape, ramp_pos, len);
        qv  = envelope_level(q_shape, ramp_pos, len);
        amp = amp_reg;
        acc = longint'(iv) * s + longint'(qv) * c;
        acc = (acc * amp) / 1073741824;
        if (acc > 32767)
            acc = 32767;
        if (acc < -32768)
            acc = -32768;
        res.audio_sample = acc[15:0];
        res.symbol_taken = 1'b0;
        ramp_pos++;
        if (ramp_pos >= len)
        begin
            sym_idx = (code > SYM_LAST) ? SYM_SAME : code;
            ph_idx  = (phase_state > PHASE_OFF) ? PHASE_OFF : phase_state;
            rule    = RULES[sym_idx][ph_idx];
            ramp_pos    = 0;
            i_shape     = rule.i_sh;
            q_shape     = rule.q_sh;
            phase_state = rule.nxt;
            res.symbol_taken = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint exp_val,
                                   input longint got_val);
        $display("[%0t] mismatch on result %0d, %s: expected %0d, got %0d",
                 $realtime, result_count, what, exp_val, got_val);
        mismatch_count++;
    endtask

    // track config, predict on request, compare on result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step    = RST_PHASE_STEP;
            sym_len       = RST_SYMBOL_LEN;
            ramp_step     = RST_RAMP_STEP;
            amp_reg       = RST_AMPLITUDE;
            carrier_phase = '0;
            ramp_pos      = 0;
            phase_state   = PHASE_OFF;
            i_shape       = SH_ZERO;
            q_shape       = SH_ZERO;
            expected_samples.delete();
            pending <= 0;
            fails   <= mismatch_count;
        end
        else
        begin
            if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
            begin
                case (cfg.index)
                    REG_PHASE_STEP: phase_step = cfg.data;
                    REG_SYMBOL_LEN: sym_len    = cfg.data[9:0];
                    REG_RAMP_STEP:  ramp_step  = cfg.data[15:0];
                    REG_AMPLITUDE:  amp_reg    = cfg.data[14:0];
                    default: ;
                endcase
            end
            if (audio.valid === 1'b1 && audio.ready === 1'b1)
            begin
                got.audio_sample = audio.audio_sample;
                got.symbol_taken = audio.symbol_taken;
                if (expected_samples.size() == 0)
                    report_mismatch("result with no request waiting", 0, got.audio_sample);
                else
                begin
                    want = expected_samples.pop_front();
                    if (got.audio_sample !== want.audio_sample)
                        report_mismatch("audio_sample", want.audio_sample, got.audio_sample);
                    if (got.symbol_taken !== want.symbol_taken)
                        report_mismatch("symbol_taken", want.symbol_taken, got.symbol_taken);
                end
                result_count++;
            end
            if (sym.valid === 1'b1 && sym.ready === 1'b1)
                expected_samples.push_back(predict_sample(sym.next_symbol));
            pending <= expected_samples.size();
            fails   <= mismatch_count;
        end
    end

endmodule

### verif/tb.sv
// Testbench top for the PSK modulator: clock, reset, stimulus, receiver stalls and verdict.
module tb;
    import psk_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_TAIL     = 40;
    localparam int NUM_PHASES     = 10;

    // symbol codes
    localparam logic [2:0] SYM_P90    = 3'd1;
    localparam logic [2:0] SYM_FLIP   = 3'd2;
    localparam logic [2:0] SYM_M90    = 3'd3;
    localparam logic [2:0] SYM_OFF    = 3'd4;
    localparam logic [2:0] SYM_ON     = 3'd5;
    localparam logic [2:0] SYM_RSVD_6 = 3'd6;
    localparam logic [2:0] SYM_RSVD_7 = 3'd7;

    // one symbol per tick, walks all phase states
    localparam logic [2:0] WALK_EVERY_TICK [10] = '{
        SYM_ON, SYM_P90, SYM_P90, SYM_P90, SYM_P90,
        SYM_FLIP, SYM_M90, SYM_RSVD_6, SYM_RSVD_7, SYM_OFF
    };
    // four ticks per symbol: neg-to-zero, then zero-to-pos shapes
    localparam logic [2:0] WALK_HALF_TEST [12] = '{
        SYM_SAME, SYM_SAME, SYM_SAME, SYM_OFF,
        SYM_RSVD_7, SYM_RSVD_7, SYM_RSVD_7, SYM_ON,
        SYM_RSVD_6, SYM_RSVD_6, SYM_RSVD_6, SYM_P90
    };

    bit   clk;
    logic rst_n;
    bit   sender_gaps;
    bit   stall_on;
    bit   hold_req;
    int   pending_results;
    int   mismatches;
    int   quiet_cycles;

    psk_sym_if   sym ();
    psk_audio_if audio ();
    psk_cfg_if   cfg ();

    psk_iq_shaped_modulator #(
        .MAX_SAMPLES_PER_SYMBOL(512),
        .SINE_TABLE_DEPTH(1024)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .sym   (sym),
        .audio (audio),
        .cfg   (cfg)
    );

    psk_sample_checker #(
        .MAX_SPS(512),
        .SINE_DEPTH(1024)
    ) u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .sym     (sym),
        .audio   (audio),
        .cfg     (cfg),
        .fails   (mismatches),
        .pending (pending_results)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // offer one symbol request, with an occasional gap before it
    task automatic send_symbol(input logic [2:0] code);
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            sym.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        sym.valid       <= 1'b1;
        sym.next_symbol <= code;
        do @(posedge clk); while (sym.ready !== 1'b1);
    endtask

    // stop offering and wait for every outstanding sample
    task automatic drain_results();
        sym.valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    // valid is left high; the caller lowers it after the last write
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (cfg.ready !== 1'b1);
    endtask

    // random bits above the field, which the block must drop
    function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
        return ($urandom() << width) | value;
    endfunction

    task automatic apply_settings(input logic [31:0] step, input logic [9:0] len,
                                  input logic [15:0] ramp, input logic [14:0] amp);
        drain_results();
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_SYMBOL_LEN, with_junk(len, 10));
        write_reg(REG_RAMP_STEP, with_junk(ramp, 16));
        write_reg(REG_AMPLITUDE, with_junk(amp, 15));
        // unused index, must be ignored
        if ($urandom_range(0, 2) == 0)
            write_reg(8'(REG_AMPLITUDE + 1 + $urandom_range(0, 251)), $urandom());
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [2:0] pick_symbol();
        if ($urandom_range(0, 9) == 0)
            return 3'(SYM_RSVD_6 + $urandom_range(0, 1));
        return 3'($urandom_range(SYM_SAME, SYM_ON));
    endfunction

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        audio.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                audio.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (stall_on && $urandom_range(0, 7) == 0)
            begin
                audio.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                audio.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sym.valid === 1'b1 && sym.ready === 1'b1) ||
                (audio.valid === 1'b1 && audio.ready === 1'b1) ||
                (cfg.valid === 1'b1 && cfg.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [31:0] step;
        logic [9:0]  len;
        logic [15:0] ramp;
        logic [14:0] amp;
        int          n_items;

        sym.valid       <= 1'b0;
        sym.next_symbol <= SYM_SAME;
        cfg.valid       <= 1'b0;
        cfg.index       <= REG_PHASE_STEP;
        cfg.data        <= '0;
        rst_n           <= 1'b0;
        sender_gaps = 1'b1;
        stall_on    = 1'b1;
        hold_req    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, carrier off
        send_symbol(SYM_ON);
        send_symbol(SYM_FLIP);

        // length 1: a symbol ends every tick; register extremes
        apply_settings(32'hFFFF_FFFF, 10'd1, 16'hFFFF, 15'h7FFF);
        @(posedge clk);
        write_reg(8'hFF, 32'hFFFF_FFFF);
        cfg.valid <= 1'b0;
        foreach (WALK_EVERY_TICK[i])
            send_symbol(WALK_EVERY_TICK[i]);

        // length 0 and all-zero registers
        apply_settings(32'h0, 10'd0, 16'h0, 15'h0);
        send_symbol(SYM_ON);
        send_symbol(SYM_FLIP);

        // short symbols around the half-symbol point, 45 degree carrier steps
        apply_settings(32'h2000_0000, 10'd4, 16'h4000, 15'h7FFF);
        foreach (WALK_HALF_TEST[i])
            send_symbol(WALK_HALF_TEST[i]);

        // random phases
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            step = ($urandom_range(0, 4) == 0) ? {32{1'($urandom_range(0, 1))}} : $urandom();
            if (p == 2)
                len = 10'd1023;
            else if ($urandom_range(0, 7) == 0)
                len = 10'($urandom_range(0, 1));
            else if ($urandom_range(0, 5) == 0)
                len = 10'($urandom_range(13, 40));
            else
                len = 10'($urandom_range(2, 12));
            if (p == 2)
                ramp = 16'd128;
            else if ($urandom_range(0, 2) == 0)
                ramp = 16'(65536 / ((len == 0) ? 1 : len));
            else if ($urandom_range(0, 5) == 0)
                ramp = {16{1'($urandom_range(0, 1))}};
            else
                ramp = 16'($urandom_range(0, 65535));
            amp = ($urandom_range(0, 4) == 0) ? {15{1'($urandom_range(0, 1))}}
                                              : 15'($urandom_range(0, 32767));
            apply_settings(step, len, ramp, amp);

            // no idling in the last part of the run
            sender_gaps = (p < NUM_PHASES - 2) && (p % 3 != 0);
            stall_on    = (p < NUM_PHASES - 2) && (p % 3 != 2);
            n_items     = (p == 2) ? 520 : 10;
            for (int i = 0; i < n_items; i++)
            begin
                if (p == 4 && i == 3)
                    hold_req = 1'b1;
                if (p == 5 && i == 6)
                    drain_results();
                send_symbol(pick_symbol());
            end
        end

        drain_results();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatches == 0 && pending_results == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
